### rtl/gisr_pkg.sv
package gisr_pkg;

  // request kinds carried in req_type; the fourth code is a no-op
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } req_kind_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SHIM_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_ACK_ENABLE   = 2'd1;
  localparam logic [1:0] CFG_PERIOD_TICKS = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned OFS_W      = 24;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned TICK_W     = 24;
  localparam int unsigned STATUS_W   = 11;

  // register map
  localparam logic [OFS_W-1:0] OFS_STATUS = 24'h00012c;
  localparam logic [OFS_W-1:0] OFS_MASK   = 24'h000130;
  localparam logic [OFS_W-1:0] OFS_CLEAR  = 24'h000134;
  localparam logic [OFS_W-1:0] OFS_IDENT  = 24'h000f00;
  localparam logic [OFS_W-1:0] OFS_MMU    = 24'h001020;

  localparam logic [DATA_W-1:0]   IDENT_VALUE  = 32'h0102_0000;
  localparam logic [DATA_W-1:0]   MMU_ACK      = 32'h0001_0000;
  localparam int unsigned         MMU_ACK_BIT  = 16;
  localparam int unsigned         MMU_REQ_BIT  = 0;
  localparam logic [STATUS_W-1:0] STATUS_FIXED = 11'h140;
  // frame-done bits and the 2D-sync bit
  localparam logic [STATUS_W-1:0] POST_BITS    = 11'h04c | 11'h400;
  localparam logic [TICK_W-1:0]   PERIOD_RESET = 24'd16000;

  // one result beat
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_level;
  } rsp_beat_t;

endpackage

### rtl/gisr_if.sv
// request channel: read, write or timer tick
interface gisr_req_if
  import gisr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [OFS_W-1:0]  reg_offset;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output req_type, output reg_offset, output write_data,
                  input ready);
  modport sink   (input valid, input req_type, input reg_offset, input write_data,
                  output ready);
endinterface

// result channel
interface gisr_rsp_if
  import gisr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq_level;

  modport source (output valid, output read_data, output irq_level, input ready);
  modport sink   (input valid, input read_data, input irq_level, output ready);
endinterface

### rtl/gisr_core.sv
module gisr_core
  import gisr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                 accept,
  input  logic [1:0]           req_type,
  input  logic [OFS_W-1:0]     reg_offset,
  input  logic [DATA_W-1:0]    write_data,
  output rsp_beat_t            beat
);

  // configuration
  logic              shim_enable;
  logic              ack_enable;
  logic [TICK_W-1:0] period_ticks;

  // register state
  logic [DATA_W-1:0]   mmu_control, mmu_control_next;
  logic                mmu_touched, mmu_touched_next;
  logic [STATUS_W-1:0] pending_status, pending_status_next;
  logic [DATA_W-1:0]   irq_mask, irq_mask_next;
  logic                timer_running, timer_running_next;
  logic [TICK_W-1:0]   ticks_left, ticks_left_next;
  logic                irq_line, irq_line_next;
  logic [DATA_W-1:0]   read_data;

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      shim_enable  <= 1'b0;
      ack_enable   <= 1'b0;
      period_ticks <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHIM_ENABLE:  shim_enable  <= cfg_data[0];
        CFG_ACK_ENABLE:   ack_enable   <= cfg_data[0];
        CFG_PERIOD_TICKS: period_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // next state and read data for the beat on the input
  always_comb begin
    logic [STATUS_W-1:0] cleared;
    logic [STATUS_W-1:0] posted;
    logic [DATA_W-1:0]   mmu_view;
    cleared = pending_status & ~write_data[STATUS_W-1:0];
    posted  = pending_status | (POST_BITS & irq_mask[STATUS_W-1:0]);
    mmu_view = mmu_control;
    if (ack_enable) begin
      mmu_view[MMU_ACK_BIT] = mmu_control[MMU_REQ_BIT];
    end
    if (!mmu_touched) begin
      mmu_view = MMU_ACK;
    end

    mmu_control_next    = mmu_control;
    mmu_touched_next    = mmu_touched;
    pending_status_next = pending_status;
    irq_mask_next       = irq_mask;
    timer_running_next  = timer_running;
    ticks_left_next     = ticks_left;
    irq_line_next       = irq_line;
    read_data           = '0;

    case (req_type)
      REQ_READ: begin
        case (reg_offset)
          OFS_STATUS: begin
            read_data = {{(DATA_W-STATUS_W){1'b0}}, STATUS_FIXED | pending_status};
            // clear on read
            if (ack_enable) begin
              pending_status_next = '0;
              irq_line_next       = 1'b0;
            end
          end
          OFS_IDENT: read_data = IDENT_VALUE;
          OFS_MMU:   read_data = mmu_view;
          default:   read_data = '0;
        endcase
      end
      REQ_WRITE: begin
        case (reg_offset)
          OFS_MMU: begin
            mmu_control_next = write_data;
            mmu_touched_next = 1'b1;
          end
          OFS_MASK: begin
            if (shim_enable) begin
              irq_mask_next = write_data;
              if (write_data != '0) begin
                timer_running_next = 1'b1;
                ticks_left_next    = period_ticks;
              end else begin
                timer_running_next  = 1'b0;
                ticks_left_next     = '0;
                pending_status_next = '0;
                irq_line_next       = 1'b0;
              end
            end
          end
          OFS_CLEAR: begin
            if (shim_enable) begin
              pending_status_next = cleared;
              if (cleared == '0) begin
                irq_line_next = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        if (timer_running && shim_enable) begin
          if (ticks_left > TICK_W'(1)) begin
            ticks_left_next = ticks_left - TICK_W'(1);
          end else if (irq_mask == '0) begin
            // expiry with nothing armed stops the timer
            timer_running_next = 1'b0;
            ticks_left_next    = '0;
          end else begin
            pending_status_next = posted;
            if (posted != '0) begin
              irq_line_next = 1'b1;
            end
            ticks_left_next = period_ticks;
          end
        end
      end
      default: ;
    endcase
  end

  // state update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mmu_control    <= '0;
      mmu_touched    <= 1'b0;
      pending_status <= '0;
      irq_mask       <= '0;
      timer_running  <= 1'b0;
      ticks_left     <= '0;
      irq_line       <= 1'b0;
    end else if (accept) begin
      mmu_control    <= mmu_control_next;
      mmu_touched    <= mmu_touched_next;
      pending_status <= pending_status_next;
      irq_mask       <= irq_mask_next;
      timer_running  <= timer_running_next;
      ticks_left     <= ticks_left_next;
      irq_line       <= irq_line_next;
    end
  end

  assign beat.read_data = read_data;
  assign beat.irq_level = irq_line_next;

endmodule

### rtl/gisr_out_reg.sv
module gisr_out_reg
  import gisr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  rsp_beat_t  beat,
  output logic       space,
  gisr_rsp_if.source rsp
);

  logic      valid;
  rsp_beat_t held;

  // free when empty or when the held beat leaves this cycle
  assign space = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      held <= beat;
    end
  end

  assign rsp.valid     = valid;
  assign rsp.read_data = held.read_data;
  assign rsp.irq_level = held.irq_level;

endmodule

### rtl/gpu_irq_status_mmu_handshake_regs.sv
// Register block for a graphics core: MMU control with request/acknowledge
// mirror, interrupt mask driving a periodic completion timer, clear-on-read
// status, write-one-to-clear register and a fixed identifier.
//
// req carries one beat per bus read, bus write or timer tick; rsp returns
// one beat for each, with read data (zero for writes and ticks) and the
// interrupt level after that request. Configuration (shim enable, ack
// enable, timer period) is written through cfg_we/cfg_index/cfg_data by the
// user while no request is in flight; the block does not enforce this.
//
// A request accepted at a clock edge has its result on rsp right after that edge.
// Throughput is one request per cycle while the receiver takes each result,
// set by the single output register; the state update is one pass of logic.
//
// Reset clears all register state and configuration (period back to 16000)
// and empties the output register. When the receiver stalls, the held
// result stays on rsp and req accepts no further beat until it is taken.
module gpu_irq_status_mmu_handshake_regs
  import gisr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gisr_req_if.sink              req,
  gisr_rsp_if.source            rsp
);

  logic      space;
  logic      accept;
  rsp_beat_t beat;

  assign req.ready = space;
  assign accept    = req.valid && space;

  gisr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .req_type   (req.req_type),
    .reg_offset (req.reg_offset),
    .write_data (req.write_data),
    .beat       (beat)
  );

  gisr_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .beat  (beat),
    .space (space),
    .rsp   (rsp)
  );

endmodule

### verif/gisr_regs_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both channels, keeps its own copy of the register
// state, and compares each accepted result beat with the oldest expected reply.
module gisr_regs_checker
  import gisr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gisr_req_if                   req,
  gisr_rsp_if                   rsp,
  output int unsigned           mismatches,
  output int unsigned           outstanding,
  output int unsigned           beats_checked,
  output int unsigned           expiries
);

  localparam int unsigned REPORT_LIMIT = 10;

  // configuration copy
  logic                  shim_on;
  logic                  ack_on;
  logic [TICK_W-1:0]     period_cfg;

  // register state copy
  logic [DATA_W-1:0]     mmu_ctrl;
  logic                  mmu_seen_wr;
  logic [STATUS_W-1:0]   status_q;
  logic [DATA_W-1:0]     mask_q;
  logic                  timer_on;
  logic [TICK_W-1:0]     ticks_rem;
  logic                  irq_q;

  rsp_beat_t             reply_q[$];
  int unsigned           bad_cnt;
  int unsigned           seen_cnt;
  int unsigned           expiry_cnt;

  // apply one request to the state copy and return the reply it should give
  function automatic rsp_beat_t regs_step(logic [1:0] kind, logic [OFS_W-1:0] ofs,
                                          logic [DATA_W-1:0] data);
    rsp_beat_t beat;
    beat.read_data = '0;
    if (kind == REQ_READ) begin
      case (ofs)
        OFS_STATUS: begin
          beat.read_data = {{(DATA_W-STATUS_W){1'b0}}, STATUS_FIXED | status_q};
          // clear-on-read only with the ack handling on
          if (ack_on) begin
            status_q = '0;
            irq_q    = 1'b0;
          end
        end
        OFS_IDENT: beat.read_data = IDENT_VALUE;
        OFS_MMU: begin
          beat.read_data = mmu_ctrl;
          if (ack_on) beat.read_data[MMU_ACK_BIT] = mmu_ctrl[MMU_REQ_BIT];
          // untouched register shows the ack bit alone
          if (!mmu_seen_wr) beat.read_data = MMU_ACK;
        end
        default: ;
      endcase
    end else if (kind == REQ_WRITE) begin
      case (ofs)
        OFS_MMU: begin
          mmu_ctrl    = data;
          mmu_seen_wr = 1'b1;
        end
        OFS_MASK: begin
          if (shim_on) begin
            mask_q = data;
            if (data != '0) begin
              timer_on  = 1'b1;
              ticks_rem = period_cfg;
            end else begin
              timer_on  = 1'b0;
              ticks_rem = '0;
              status_q  = '0;
              irq_q     = 1'b0;
            end
          end
        end
        OFS_CLEAR: begin
          if (shim_on) begin
            status_q = status_q & ~data[STATUS_W-1:0];
            if (status_q == '0) irq_q = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (kind == REQ_TICK) begin
      // frozen while the shim is off
      if (timer_on && shim_on) begin
        if (ticks_rem > 1) begin
          ticks_rem = ticks_rem - 1'b1;
        end else if (mask_q == '0) begin
          timer_on  = 1'b0;
          ticks_rem = '0;
        end else begin
          status_q = status_q | (POST_BITS & mask_q[STATUS_W-1:0]);
          if (status_q != '0) irq_q = 1'b1;
          timer_on   = 1'b1;
          ticks_rem  = period_cfg;
          expiry_cnt = expiry_cnt + 1;
        end
      end
    end
    beat.irq_level = irq_q;
    return beat;
  endfunction

  always @(posedge clk) begin : watch
    rsp_beat_t want;
    if (rst) begin
      shim_on     = 1'b0;
      ack_on      = 1'b0;
      period_cfg  = PERIOD_RESET;
      mmu_ctrl    = '0;
      mmu_seen_wr = 1'b0;
      status_q    = '0;
      mask_q      = '0;
      timer_on    = 1'b0;
      ticks_rem   = '0;
      irq_q       = 1'b0;
      reply_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHIM_ENABLE:  shim_on    = cfg_data[0];
          CFG_ACK_ENABLE:   ack_on     = cfg_data[0];
          CFG_PERIOD_TICKS: period_cfg = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      // predict before comparing, so the reply is always queued first
      if (req.valid && req.ready)
        reply_q.push_back(regs_step(req.req_type, req.reg_offset, req.write_data));
      if (rsp.valid && rsp.ready) begin
        if (reply_q.size() == 0) begin
          bad_cnt = bad_cnt + 1;
          if (bad_cnt <= REPORT_LIMIT)
            $display("unexpected result beat: read_data %08h irq %0b",
                     rsp.read_data, rsp.irq_level);
        end else begin
          want     = reply_q.pop_front();
          seen_cnt = seen_cnt + 1;
          if (rsp.read_data !== want.read_data || rsp.irq_level !== want.irq_level) begin
            bad_cnt = bad_cnt + 1;
            if (bad_cnt <= REPORT_LIMIT)
              $display("beat %0d: expected read_data %08h irq %0b, got read_data %08h irq %0b",
                       seen_cnt, want.read_data, want.irq_level,
                       rsp.read_data, rsp.irq_level);
          end
        end
      end
    end
    mismatches    <= bad_cnt;
    outstanding   <= reply_q.size();
    beats_checked <= seen_cnt;
    expiries      <= expiry_cnt;
  end

endmodule

### verif/gpu_irq_status_mmu_handshake_regs_tb.sv
`timescale 1ns / 1ps

module gpu_irq_status_mmu_handshake_regs_tb;
  import gisr_pkg::*;

  localparam logic [1:0]  REQ_NONE        = 2'd3;
  localparam int unsigned MAX_GAP         = 18;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 75;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned           mismatches;
  int unsigned           outstanding;
  int unsigned           beats_checked;
  int unsigned           expiries;

  // when set, that side never idles
  bit                    send_busy;
  bit                    recv_busy;
  int unsigned           n_read, n_write, n_tick, n_none;

  gisr_req_if req_ch();
  gisr_rsp_if rsp_ch();

  gpu_irq_status_mmu_handshake_regs i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  gisr_regs_checker i_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .beats_checked (beats_checked),
    .expiries      (expiries)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned draw_gap(bit busy);
    return busy ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [OFS_W-1:0] reg_at(int unsigned i);
    case (i)
      0:       return OFS_STATUS;
      1:       return OFS_MASK;
      2:       return OFS_CLEAR;
      3:       return OFS_IDENT;
      default: return OFS_MMU;
    endcase
  endfunction

  // result side: random stall before each beat
  initial begin : recv
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_gap(recv_busy);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // one request beat; valid stays high into the next beat when there is no gap
  task automatic send_item(input logic [1:0] kind, input logic [OFS_W-1:0] ofs,
                           input logic [DATA_W-1:0] data);
    int unsigned gap;
    gap = draw_gap(send_busy);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.reg_offset <= ofs;
    req_ch.write_data <= data;
    do @(posedge clk); while (!req_ch.ready);
    case (kind)
      REQ_READ:  n_read++;
      REQ_WRITE: n_write++;
      REQ_TICK:  n_tick++;
      default:   n_none++;
    endcase
  endtask

  // mostly mapped registers, some near misses and random offsets
  task automatic send_random;
    int unsigned       sel;
    logic [1:0]        kind;
    logic [OFS_W-1:0]  ofs;
    logic [DATA_W-1:0] data;
    sel = $urandom_range(0, 99);
    if (sel < 38)      kind = REQ_TICK;
    else if (sel < 66) kind = REQ_READ;
    else if (sel < 95) kind = REQ_WRITE;
    else               kind = REQ_NONE;
    sel = $urandom_range(0, 15);
    if (sel < 12)      ofs = reg_at(sel % 5);
    else if (sel < 14) ofs = reg_at($urandom_range(0, 4)) ^ (24'd1 << $urandom_range(0, OFS_W-1));
    else               ofs = OFS_W'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 1)       data = '0;
    else if (sel < 4)  data = $urandom_range(0, 2047);
    else if (sel < 5)  data = $urandom & 32'h0001_0001;
    else               data = $urandom;
    send_item(kind, ofs, data);
  endtask

  // stop sending and wait for every reply to come back
  task automatic drain_replies;
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_phase(input bit shim, input bit ack, input logic [TICK_W-1:0] period);
    drain_replies();
    write_cfg(CFG_SHIM_ENABLE, CFG_DATA_W'(shim));
    write_cfg(CFG_ACK_ENABLE, CFG_DATA_W'(ack));
    write_cfg(CFG_PERIOD_TICKS, period);
    send_busy = ($urandom_range(0, 3) == 0);
    recv_busy = ($urandom_range(0, 3) == 0);
  endtask

  initial begin : stim
    bit                shim;
    logic [TICK_W-1:0] period;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_READ;
    req_ch.reg_offset = '0;
    req_ch.write_data = '0;
    send_busy         = 1'b0;
    recv_busy         = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: fixed reads, untouched MMU, ignored writes, no-op type
    send_item(REQ_READ,  OFS_MMU,    '0);
    send_item(REQ_READ,  OFS_IDENT,  '0);
    send_item(REQ_READ,  OFS_STATUS, '0);
    send_item(REQ_READ,  OFS_MASK,   '0);
    send_item(REQ_READ,  24'hff_ffff, '0);
    send_item(REQ_WRITE, OFS_STATUS, 32'hffff_ffff);
    send_item(REQ_WRITE, OFS_MASK,   32'hffff_ffff);
    send_item(REQ_NONE,  OFS_STATUS, 32'hffff_ffff);
    send_item(REQ_TICK,  '0,         '0);

    // shim and ack on, short period: mirror, expiry, clear paths
    set_phase(1'b1, 1'b1, 24'd2);
    send_item(REQ_WRITE, OFS_MMU,    32'h0000_0001);
    send_item(REQ_READ,  OFS_MMU,    '0);
    send_item(REQ_WRITE, OFS_MMU,    32'hfffe_fffe);
    send_item(REQ_READ,  OFS_MMU,    '0);
    send_item(REQ_WRITE, OFS_MASK,   32'hffff_ffff);
    send_item(REQ_TICK,  '0,         '0);
    send_item(REQ_TICK,  '0,         '0);
    send_item(REQ_READ,  OFS_STATUS, '0);
    send_item(REQ_TICK,  '0,         '0);
    send_item(REQ_TICK,  '0,         '0);
    send_item(REQ_WRITE, OFS_CLEAR,  32'h0000_0004);
    send_item(REQ_WRITE, OFS_CLEAR,  32'hffff_ffff);
    send_item(REQ_WRITE, OFS_MASK,   '0);

    // zero period behaves as one tick; status read without clearing
    set_phase(1'b1, 1'b0, '0);
    send_item(REQ_WRITE, OFS_MASK,   32'h0000_0400);
    send_item(REQ_TICK,  '0,         '0);
    send_item(REQ_READ,  OFS_STATUS, '0);
    send_item(REQ_READ,  OFS_MMU,    '0);

    // random phases over several settings, extremes included
    for (int p = 0; p < PHASES; p++) begin
      shim = (p == 3) ? 1'b0 : ($urandom_range(0, 4) != 0);
      if (p == 2)      period = '1;
      else if (p == 5) period = '0;
      else             period = TICK_W'($urandom_range(1, 6));
      set_phase(shim, ($urandom_range(0, 1) != 0), period);
      repeat (ITEMS_PER_PHASE) send_random();
    end

    drain_replies();
    $display("checked %0d result beats: %0d reads, %0d writes, %0d ticks, %0d no-op requests",
             beats_checked, n_read, n_write, n_tick, n_none);
    $display("%0d timer expiries predicted over %0d configuration phases",
             expiries, PHASES + 2);
    if (mismatches == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
